// ===== sv/dht_pkg.sv =====
// ----------------------------------------------------------------------------
// dht_pkg
// shared constants, types and codes of the double hashing table
// ----------------------------------------------------------------------------
package dht_pkg;

  localparam int MAX_SLOTS = 1024;
  localparam int KEY_W     = 31;
  localparam int SLOT_W    = $clog2(MAX_SLOTS);
  localparam int SIZE_W    = $clog2(MAX_SLOTS + 1);
  localparam int CNT_W     = $clog2(KEY_W);
  localparam int IN_DATA_W  = ((KEY_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((SLOT_W + SIZE_W + 7) / 8) * 8;
  localparam int CFG_W      = 11;

  localparam logic [CFG_W-1:0] SIZE_RESET = CFG_W'(11);

  typedef enum logic [1:0] {
    STATUS_OK   = 2'd0,
    STATUS_MISS = 2'd1,
    STATUS_FULL = 2'd2
  } status_e;

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_SEARCH = 1'b1;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MOD_HOME,
    S_MOD_STEP,
    S_READ,
    S_CHECK,
    S_DONE
  } state_e;

  // request to the shared remainder unit
  typedef struct packed {
    logic              start;
    logic [KEY_W-1:0]  dividend;
    logic [SIZE_W-1:0] divisor;
  } mod_req_t;

  typedef struct packed {
    logic              done;
    logic [SLOT_W-1:0] rem;
  } mod_rsp_t;

  // access to the slot store
  typedef struct packed {
    logic              key_we;
    logic              used_we;
    logic              used_wdata;
    logic [SLOT_W-1:0] addr;
    logic [KEY_W-1:0]  key;
  } slot_req_t;

  typedef struct packed {
    logic             used;
    logic [KEY_W-1:0] key;
  } slot_rsp_t;

endpackage

// ===== sv/dht_mod_unit.sv =====
// ----------------------------------------------------------------------------
// dht_mod_unit
// bit-serial remainder unit, one dividend bit per cycle
// ----------------------------------------------------------------------------
module dht_mod_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dht_pkg::mod_req_t req_i,
  output dht_pkg::mod_rsp_t rsp_o
);
  import dht_pkg::*;

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [KEY_W-1:0]  dvd_q, dvd_d;
  logic [SIZE_W-1:0] div_q, div_d;
  logic [SLOT_W-1:0] rem_q, rem_d;
  logic [SLOT_W:0]   trial;
  logic              fits;

  always_comb begin
    trial  = {rem_q, dvd_q[KEY_W-1]};
    fits   = trial >= (SLOT_W+1)'(div_q);
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    div_d  = div_q;
    rem_d  = rem_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(KEY_W - 1);
      dvd_d  = req_i.dividend;
      div_d  = req_i.divisor;
      rem_d  = '0;
    end else if (busy_q) begin
      // restoring step: bring in the next bit, subtract when it fits
      rem_d = fits ? SLOT_W'(trial - (SLOT_W+1)'(div_q)) : SLOT_W'(trial);
      dvd_d = {dvd_q[KEY_W-2:0], 1'b0};
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    div_q <= div_d;
    rem_q <= rem_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.rem  = rem_q;

endmodule

// ===== sv/dht_slot_mem.sv =====
// ----------------------------------------------------------------------------
// dht_slot_mem
// key store and occupancy store, one port each, registered read
// ----------------------------------------------------------------------------
module dht_slot_mem (
  input  logic               clk_i,
  input  dht_pkg::slot_req_t req_i,
  output dht_pkg::slot_rsp_t rsp_o
);
  import dht_pkg::*;

  logic [KEY_W-1:0] key_mem [MAX_SLOTS];
  logic             used_mem [MAX_SLOTS];
  logic [KEY_W-1:0] key_rd_q;
  logic             used_rd_q;

  always_ff @(posedge clk_i) begin
    if (req_i.key_we) begin
      key_mem[req_i.addr] <= req_i.key;
    end
    key_rd_q <= key_mem[req_i.addr];
  end

  always_ff @(posedge clk_i) begin
    if (req_i.used_we) begin
      used_mem[req_i.addr] <= req_i.used_wdata;
    end
    used_rd_q <= used_mem[req_i.addr];
  end

  assign rsp_o.used = used_rd_q;
  assign rsp_o.key  = key_rd_q;

endmodule

// ===== sv/double_hash_table.sv =====
// ----------------------------------------------------------------------------
// double_hash_table
// open addressing hash table of keys with double hashing
// ----------------------------------------------------------------------------
// Each input word is an insert (tuser 0) or a search (tuser 1) of a 31-bit
// key and gives one result word. The home slot is key mod size and the step
// is 1 + key mod (size-1); both remainders come from one bit-serial unit.
// After that each slot checked passes through a slot store read state and
// then a check state, and a done state moves the result into the output
// register once that register is free or its word is being taken. A new
// request word is taken only after that hand-over. At most table_size
// probes are made; an insert on a full table reports full, a search that
// never meets an empty slot reports a miss. After reset a clearing pass
// over all MAX_SLOTS (1024) slots empties the occupancy store, and no
// request is taken until it ends. table_size is written through the cfg
// channel (always ready); values below 2 act as 2, above 1024 as 1024.
// Write it only while idle and with an empty table.
// ----------------------------------------------------------------------------
module double_hash_table (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration: table_size
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [dht_pkg::CFG_W-1:0]       cfg_data_i,
  // request words
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [dht_pkg::IN_DATA_W-1:0]   s_axis_tdata,  // key, zero padding
  input  logic                            s_axis_tuser,  // req_type
  // result words
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [dht_pkg::OUT_DATA_W-1:0]  m_axis_tdata,  // slot, probes, padding
  output logic [1:0]                      m_axis_tuser   // status
);
  import dht_pkg::*;

  state_e            state_q, state_d;
  logic [CFG_W-1:0]  cfg_q;
  logic [SIZE_W-1:0] size_eff;

  // request context
  logic              req_q, req_d;
  logic [KEY_W-1:0]  key_q, key_d;
  logic [SIZE_W-1:0] size_q, size_d;
  logic [SLOT_W-1:0] pos_q, pos_d;
  logic [SLOT_W-1:0] step_q, step_d;
  logic [SIZE_W-1:0] cnt_q, cnt_d;
  logic [SLOT_W-1:0] clr_q, clr_d;

  // finished result, waiting for the output register
  status_e           res_status_q, res_status_d;
  logic [SLOT_W-1:0] res_slot_q, res_slot_d;
  logic [SIZE_W-1:0] res_probes_q, res_probes_d;

  // output register
  logic              out_valid_q, out_valid_d;
  status_e           out_status_q, out_status_d;
  logic [SLOT_W-1:0] out_slot_q, out_slot_d;
  logic [SIZE_W-1:0] out_probes_q, out_probes_d;

  mod_req_t          mod_req;
  mod_rsp_t          mod_rsp;
  slot_req_t         mem_req;
  slot_rsp_t         mem_rsp;

  logic              in_fire;
  logic [SLOT_W:0]   pos_sum;
  logic [SIZE_W-1:0] cnt_inc;

  dht_mod_unit u_mod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mod_req),
    .rsp_o  (mod_rsp)
  );

  dht_slot_mem u_mem (
    .clk_i (clk_i),
    .req_i (mem_req),
    .rsp_o (mem_rsp)
  );

  // configuration register, taken any time
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= SIZE_RESET;
    end else if (cfg_valid_i) begin
      cfg_q <= cfg_data_i;
    end
  end

  // clamp the configured size to the supported range
  always_comb begin
    if (SIZE_W'(cfg_q) < SIZE_W'(2)) begin
      size_eff = SIZE_W'(2);
    end else if (SIZE_W'(cfg_q) > SIZE_W'(MAX_SLOTS)) begin
      size_eff = SIZE_W'(MAX_SLOTS);
    end else begin
      size_eff = SIZE_W'(cfg_q);
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  // next probe position, pos + step stays below twice the size
  assign pos_sum = {1'b0, pos_q} + {1'b0, step_q};
  assign cnt_inc = cnt_q + SIZE_W'(1);

  always_comb begin
    state_d      = state_q;
    req_d        = req_q;
    key_d        = key_q;
    size_d       = size_q;
    pos_d        = pos_q;
    step_d       = step_q;
    cnt_d        = cnt_q;
    clr_d        = clr_q;
    res_status_d = res_status_q;
    res_slot_d   = res_slot_q;
    res_probes_d = res_probes_q;
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_slot_d   = out_slot_q;
    out_probes_d = out_probes_q;

    mod_req.start    = 1'b0;
    mod_req.dividend = key_q;
    mod_req.divisor  = size_q;

    mem_req.key_we     = 1'b0;
    mem_req.used_we    = 1'b0;
    mem_req.used_wdata = 1'b0;
    mem_req.addr       = pos_q;
    mem_req.key        = key_q;

    // output word leaves
    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_CLEAR: begin
        // empty one slot per cycle
        mem_req.used_we    = 1'b1;
        mem_req.used_wdata = 1'b0;
        mem_req.addr       = clr_q;
        clr_d              = clr_q + SLOT_W'(1);
        if (clr_q == SLOT_W'(MAX_SLOTS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          req_d            = s_axis_tuser;
          key_d            = s_axis_tdata[KEY_W-1:0];
          size_d           = size_eff;
          mod_req.start    = 1'b1;
          mod_req.dividend = s_axis_tdata[KEY_W-1:0];
          mod_req.divisor  = size_eff;
          state_d          = S_MOD_HOME;
        end
      end
      S_MOD_HOME: begin
        if (mod_rsp.done) begin
          pos_d            = mod_rsp.rem;
          mod_req.start    = 1'b1;
          mod_req.divisor  = size_q - SIZE_W'(1);
          state_d          = S_MOD_STEP;
        end
      end
      S_MOD_STEP: begin
        if (mod_rsp.done) begin
          step_d  = mod_rsp.rem + SLOT_W'(1);
          cnt_d   = '0;
          state_d = S_READ;
        end
      end
      S_READ: begin
        // address is pos_q, data is back next cycle
        state_d = S_CHECK;
      end
      S_CHECK: begin
        if (!mem_rsp.used) begin
          res_probes_d = cnt_q;
          if (req_q == REQ_SEARCH) begin
            res_status_d = STATUS_MISS;
            res_slot_d   = '0;
          end else begin
            mem_req.key_we     = 1'b1;
            mem_req.used_we    = 1'b1;
            mem_req.used_wdata = 1'b1;
            res_status_d       = STATUS_OK;
            res_slot_d         = pos_q;
          end
          state_d = S_DONE;
        end else if (req_q == REQ_SEARCH && mem_rsp.key == key_q) begin
          res_status_d = STATUS_OK;
          res_slot_d   = pos_q;
          res_probes_d = cnt_q;
          state_d      = S_DONE;
        end else if (cnt_inc == size_q) begin
          // probe bound reached
          res_status_d = (req_q == REQ_SEARCH) ? STATUS_MISS : STATUS_FULL;
          res_slot_d   = '0;
          res_probes_d = size_q;
          state_d      = S_DONE;
        end else begin
          cnt_d = cnt_inc;
          if (pos_sum >= (SLOT_W+1)'(size_q)) begin
            pos_d = SLOT_W'(pos_sum - (SLOT_W+1)'(size_q));
          end else begin
            pos_d = SLOT_W'(pos_sum);
          end
          state_d = S_READ;
        end
      end
      S_DONE: begin
        // hand over once the output register is free
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_slot_d   = res_slot_q;
          out_probes_d = res_probes_q;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q        <= req_d;
    key_q        <= key_d;
    size_q       <= size_d;
    pos_q        <= pos_d;
    step_q       <= step_d;
    res_status_q <= res_status_d;
    res_slot_q   <= res_slot_d;
    res_probes_q <= res_probes_d;
    out_status_q <= out_status_d;
    out_slot_q   <= out_slot_d;
    out_probes_q <= out_probes_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tdata  = OUT_DATA_W'({out_probes_q, out_slot_q});

endmodule

// ===== sv/dht_checker.sv =====
// ----------------------------------------------------------------------------
// dht_checker
// port-level checks of the double hashing table, bound to the top level
// ----------------------------------------------------------------------------
module dht_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [dht_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  input logic [1:0]                      m_axis_tuser
);
  import dht_pkg::*;

  localparam logic [1:0] CODE_OK = STATUS_OK;
  localparam logic [1:0] CODE_MISS = STATUS_MISS;
  localparam logic [1:0] CODE_FULL = STATUS_FULL;

  // a stalled result word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result word changed while stalled");

  // status is one of the three codes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      (m_axis_tuser == CODE_OK || m_axis_tuser == CODE_MISS || m_axis_tuser == CODE_FULL))
    else $error("undefined status code");

  // misses and full inserts report slot zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != CODE_OK |-> m_axis_tdata[SLOT_W-1:0] == '0)
    else $error("nonzero slot on failed request");

  // probe count never exceeds the slot count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[SLOT_W+SIZE_W-1:SLOT_W] <= SIZE_W'(MAX_SLOTS))
    else $error("probe count out of range");

  // one request at a time: no new word right after one is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request taken while busy");

endmodule

bind double_hash_table dht_checker u_dht_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

// ===== tb/double_hash_table_test.sv =====
// ----------------------------------------------------------------------------
// double_hash_table_test
// self-checking bench of the double hashing table
// ----------------------------------------------------------------------------
// A table of directed words walks the table sizes at and past their limits,
// and covers duplicate inserts, full tables, exhausted searches and resizes
// of a table that is not empty. Random phases follow at several sizes and mix
// searches for stored keys, colliding and random inserts, and misses. Every
// result word is checked against its typed value or a predictor with its own
// copy of the slot store and the table size. The sender runs in bursts, and
// the receiver stalls on a pattern of its own, with one long hold-off.
// ----------------------------------------------------------------------------
module double_hash_table_test;
  import dht_pkg::*;

  localparam int CYCLE_LIMIT = 20_000_000; // generous, covers worst-case probe chains
  localparam int LONG_HOLD   = 300;        // receiver hold-off, in cycles
  localparam int SETTLE      = 8;          // quiet cycles before a size write
  localparam int END_SETTLE  = 200;        // quiet cycles before the verdict
  localparam int NUM_ROWS    = 26;
  localparam int NUM_PHASES  = 6;

  typedef struct packed {
    status_e             status;
    logic [SLOT_W-1:0]   slot;
    logic [SIZE_W-1:0]   probes;
  } dht_result_t;

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e           kind;
    logic [CFG_W-1:0]    cfg_value;  // size to write on a config row
    logic                req;        // insert or search
    logic [KEY_W-1:0]    key;
    logic                typed;      // result below is the expected one
    dht_result_t         res;
  } dir_row_t;

  typedef enum logic [1:0] {RX_STEADY, RX_COIN, RX_PATTERN, RX_SPARSE} rx_mode_e;

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   cfg_valid_i;
  logic                   cfg_ready_o;
  logic [CFG_W-1:0]       cfg_data_i;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_DATA_W-1:0]   s_axis_tdata;   // key, zero padding
  logic                   s_axis_tuser;   // req_type
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_DATA_W-1:0]  m_axis_tdata;   // slot, probes, zero padding
  logic [1:0]             m_axis_tuser;   // status

  // predictor copy of the table
  logic [KEY_W-1:0]       shadow_keys [MAX_SLOTS];
  bit                     shadow_used [MAX_SLOTS];
  logic [CFG_W-1:0]       size_setting;

  dht_result_t            awaited_results [$];
  dht_result_t            want_res;
  dht_result_t            pred_res;
  dir_row_t               dir_rows [NUM_ROWS];

  // expectation of the word on offer, set together with its data
  logic                   row_typed;
  dht_result_t            row_result;

  int                     err_count;
  int                     cycle_count;
  int                     long_hold_asked;
  int                     n_insert, n_search, n_ok, n_miss, n_full;

  double_hash_table DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // walk the probe sequence on the shadow table and update it like the block
  function automatic void probe_table(input logic req, input logic [KEY_W-1:0] k,
                                      output dht_result_t r);
    int unsigned s, pos, step, j;
    bit          decided;
    s = size_setting;
    if (s < 2) s = 2;                       // tiny sizes act as two slots
    if (s > MAX_SLOTS) s = MAX_SLOTS;       // oversize acts as the full store
    pos = k % s;
    step = 1 + k % (s - 1);
    decided = 1'b0;
    r = '{STATUS_OK, '0, '0};
    for (j = 0; j < s && !decided; j++) begin
      if (!shadow_used[pos]) begin
        decided = 1'b1;
        if (req == REQ_SEARCH) begin
          r = '{STATUS_MISS, '0, SIZE_W'(j)};   // miss at an empty slot
        end else begin
          shadow_used[pos] = 1'b1;
          shadow_keys[pos] = k;
          r = '{STATUS_OK, SLOT_W'(pos), SIZE_W'(j)};
        end
      end else if (req == REQ_SEARCH && shadow_keys[pos] == k) begin
        decided = 1'b1;
        r = '{STATUS_OK, SLOT_W'(pos), SIZE_W'(j)};
      end else begin
        pos = (pos + step) % s;
      end
    end
    // every probe met another key: full on insert, exhausted on search
    if (!decided) begin
      r = '{(req == REQ_SEARCH) ? STATUS_MISS : STATUS_FULL, '0, SIZE_W'(s)};
    end
  endfunction

  // put one request word on the bus and hold it until taken
  task automatic offer(input logic req, input logic [KEY_W-1:0] k,
                       input logic typed, input dht_result_t res);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(IN_DATA_W-KEY_W){1'b0}}, k};
    s_axis_tuser  <= req;
    row_typed  = typed;
    row_result = res;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // stop sending and let every awaited result come back
  task automatic wait_idle(input int settle);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  task automatic write_size(input logic [CFG_W-1:0] v);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    size_setting = v;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // result check first, then the prediction of a word taken at the same edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (awaited_results.size() == 0) begin
          err_count++;
          $display("%0t: unexpected result word, status %0d slot %0d probes %0d", $time,
                   m_axis_tuser, m_axis_tdata[SLOT_W-1:0],
                   m_axis_tdata[SLOT_W+SIZE_W-1:SLOT_W]);
        end else begin
          want_res = awaited_results.pop_front();
          if (m_axis_tuser !== want_res.status) begin
            err_count++;
            $display("%0t: status expected %0d actual %0d", $time, want_res.status,
                     m_axis_tuser);
          end
          if (m_axis_tdata[SLOT_W-1:0] !== want_res.slot) begin
            err_count++;
            $display("%0t: slot expected %0d actual %0d", $time, want_res.slot,
                     m_axis_tdata[SLOT_W-1:0]);
          end
          if (m_axis_tdata[SLOT_W+SIZE_W-1:SLOT_W] !== want_res.probes) begin
            err_count++;
            $display("%0t: probes expected %0d actual %0d", $time, want_res.probes,
                     m_axis_tdata[SLOT_W+SIZE_W-1:SLOT_W]);
          end
          case (want_res.status)
            STATUS_OK:   n_ok++;
            STATUS_MISS: n_miss++;
            default:     n_full++;
          endcase
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        // the predictor always runs so that the shadow table stays in step
        probe_table(s_axis_tuser, s_axis_tdata[KEY_W-1:0], pred_res);
        awaited_results.push_back(row_typed ? row_result : pred_res);
        if (s_axis_tuser == REQ_SEARCH) n_search++;
        else n_insert++;
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results still awaited", $time,
               awaited_results.size());
      $display("double_hash_table_test: errors");
      $finish;
    end
  end

  // receiver: stalls on its own pattern, and serves long hold-off requests
  initial begin : rx_side
    int       served;
    int       phase;
    rx_mode_e mode;
    logic [7:0] pat;
    served = 0;
    phase  = 0;
    mode   = RX_STEADY;
    pat    = 8'hA5;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (long_hold_asked > served) begin
        served++;
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk_i);
      end else begin
        // a fresh stall mode and pattern are drawn when the phase count wraps, steady stretches among them
        if (phase % 64 == 0) begin
          mode = rx_mode_e'($urandom_range(0, 3));
          pat  = 8'($urandom) | 8'h01;
        end
        phase++;
        case (mode)
          RX_STEADY:  m_axis_tready <= 1'b1;
          RX_COIN:    m_axis_tready <= ($urandom_range(0, 1) == 1);
          RX_PATTERN: m_axis_tready <= pat[phase % 8];
          default:    m_axis_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  initial begin : stimulus
    int               p, i, gap, burst_left, pick, collide_home;
    int unsigned      eff;
    logic             req;
    logic [KEY_W-1:0] k;
    logic [KEY_W-1:0] known_keys [$];
    int               phase_sizes [NUM_PHASES];
    int               phase_items [NUM_PHASES];

    // known values on every input from time zero
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = REQ_INSERT;
    row_typed     = 1'b0;
    row_result    = '{STATUS_OK, '0, '0};
    size_setting  = SIZE_RESET;
    for (i = 0; i < MAX_SLOTS; i++) begin
      shadow_used[i] = 1'b0;
      shadow_keys[i] = '0;
    end
    err_count = 0;
    cycle_count = 0;
    long_hold_asked = 0;
    n_insert = 0; n_search = 0; n_ok = 0; n_miss = 0; n_full = 0;

    // directed words; results typed in only where obvious
    dir_rows = '{
      // reset size of 11, empty table
      '{ROW_REQ, 11'd0, REQ_SEARCH, 31'd0, 1'b1, '{STATUS_MISS, 10'd0, 11'd0}},
      '{ROW_REQ, 11'd0, REQ_INSERT, 31'd0, 1'b1, '{STATUS_OK, 10'd0, 11'd0}},
      '{ROW_REQ, 11'd0, REQ_SEARCH, 31'd0, 1'b1, '{STATUS_OK, 10'd0, 11'd0}},
      // duplicate insert lands one step further
      '{ROW_REQ, 11'd0, REQ_INSERT, 31'd0, 1'b0, '{STATUS_OK, 10'd0, 11'd0}},
      '{ROW_REQ, 11'd0, REQ_INSERT, 31'h7FFF_FFFF, 1'b0, '{STATUS_OK, 10'd0, 11'd0}},
      '{ROW_REQ, 11'd0, REQ_SEARCH, 31'h7FFF_FFFF, 1'b0, '{STATUS_OK, 10'd0, 11'd0}},
      '{ROW_REQ, 11'd0, REQ_SEARCH, 31'd22, 1'b0, '{STATUS_OK, 10'd0, 11'd0}},
      '{ROW_REQ, 11'd0, REQ_INSERT, 31'h2AAA_AAAA, 1'b0, '{STATUS_OK, 10'd0, 11'd0}},
      '{ROW_REQ, 11'd0, REQ_INSERT, 31'h5555_5555, 1'b0, '{STATUS_OK, 10'd0, 11'd0}},
      // size 0 acts as 2, both slots already hold key 0
      '{ROW_CFG, 11'd0, REQ_INSERT, 31'd0, 1'b0, '{STATUS_OK, 10'd0, 11'd0}},
      '{ROW_REQ, 11'd0, REQ_INSERT, 31'd5, 1'b1, '{STATUS_FULL, 10'd0, 11'd2}},
      '{ROW_REQ, 11'd0, REQ_SEARCH, 31'd5, 1'b1, '{STATUS_MISS, 10'd0, 11'd2}},
      '{ROW_REQ, 11'd0, REQ_SEARCH, 31'd0, 1'b1, '{STATUS_OK, 10'd0, 11'd0}},
      '{ROW_CFG, 11'd1, REQ_INSERT, 31'd0, 1'b0, '{STATUS_OK, 10'd0, 11'd0}},
      '{ROW_REQ, 11'd0, REQ_INSERT, 31'd3, 1'b1, '{STATUS_FULL, 10'd0, 11'd2}},
      // all-ones size acts as the full store, top slot still empty
      '{ROW_CFG, 11'd2047, REQ_INSERT, 31'd0, 1'b0, '{STATUS_OK, 10'd0, 11'd0}},
      '{ROW_REQ, 11'd0, REQ_INSERT, 31'd1023, 1'b1, '{STATUS_OK, 10'd1023, 11'd0}},
      '{ROW_REQ, 11'd0, REQ_SEARCH, 31'd1023, 1'b1, '{STATUS_OK, 10'd1023, 11'd0}},
      '{ROW_REQ, 11'd0, REQ_INSERT, 31'd2047, 1'b0, '{STATUS_OK, 10'd0, 11'd0}},
      '{ROW_REQ, 11'd0, REQ_SEARCH, 31'h7FFF_FFFF, 1'b0, '{STATUS_OK, 10'd0, 11'd0}},
      '{ROW_CFG, 11'd1024, REQ_INSERT, 31'd0, 1'b0, '{STATUS_OK, 10'd0, 11'd0}},
      '{ROW_REQ, 11'd0, REQ_SEARCH, 31'd2047, 1'b0, '{STATUS_OK, 10'd0, 11'd0}},
      // non-prime size, probe sequences may revisit slots
      '{ROW_CFG, 11'd4, REQ_INSERT, 31'd0, 1'b0, '{STATUS_OK, 10'd0, 11'd0}},
      '{ROW_REQ, 11'd0, REQ_INSERT, 31'd2, 1'b0, '{STATUS_OK, 10'd0, 11'd0}},
      '{ROW_REQ, 11'd0, REQ_INSERT, 31'd6, 1'b0, '{STATUS_OK, 10'd0, 11'd0}},
      '{ROW_REQ, 11'd0, REQ_SEARCH, 31'd10, 1'b0, '{STATUS_OK, 10'd0, 11'd0}}
    };

    // random phases: size and word count of each
    phase_sizes = '{13, 1024, 6, 97, 2, 1000};
    phase_items = '{120, 200, 60, 150, 40, 180};

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed part; the block's clearing pass just holds off the first word
    foreach (dir_rows[r]) begin
      if (dir_rows[r].kind == ROW_CFG) begin
        wait_idle(SETTLE);
        write_size(dir_rows[r].cfg_value);
      end else begin
        offer(dir_rows[r].req, dir_rows[r].key, dir_rows[r].typed, dir_rows[r].res);
      end
    end

    burst_left = 0;
    for (p = 0; p < NUM_PHASES; p++) begin
      wait_idle(SETTLE);
      write_size(CFG_W'(phase_sizes[p]));
      eff = phase_sizes[p];
      collide_home = $urandom_range(0, eff - 1);
      // long output stall while the sender keeps offering
      if (p == 1) long_hold_asked++;
      for (i = 0; i < phase_items[p]; i++) begin
        // sender pause until every result is back
        if (i == phase_items[p] / 2) wait_idle(0);
        if (burst_left == 0) begin
          gap = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 90 : 12);
          @(negedge clk_i);
          s_axis_tvalid <= 1'b0;
          repeat (gap - 1) @(negedge clk_i);
          burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        pick = $urandom_range(0, 99);
        if (pick < 40 && known_keys.size() > 0) begin
          // search for a key that was stored earlier
          req = REQ_SEARCH;
          k = known_keys[$urandom_range(0, known_keys.size() - 1)];
        end else if (pick < 75) begin
          req = REQ_INSERT;
          case ($urandom_range(0, 2))
            0:       k = KEY_W'($urandom);
            1:       k = KEY_W'($urandom_range(0, 4 * eff));
            default: k = KEY_W'(collide_home + eff * $urandom_range(0, 5000));
          endcase
          known_keys.push_back(k);
          if (known_keys.size() > 256) void'(known_keys.pop_front());
        end else begin
          // mostly misses
          req = REQ_SEARCH;
          k = KEY_W'($urandom);
        end
        offer(req, k, 1'b0, '{STATUS_OK, '0, '0});
      end
    end

    wait_idle(END_SETTLE);

    $display("covered %0d inserts and %0d searches over table sizes 0 to 2047",
             n_insert, n_search);
    $display("results: %0d stored or found, %0d missed, %0d table full",
             n_ok, n_miss, n_full);
    if (err_count == 0) begin
      $display("double_hash_table_test: clean");
    end else begin
      $display("double_hash_table_test: errors");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/dht_pkg.sv
sv/dht_mod_unit.sv
sv/dht_slot_mem.sv
sv/double_hash_table.sv
sv/dht_checker.sv
tb/double_hash_table_test.sv
